[sv/aled_pkg.sv]
`timescale 1ns / 1ps
package aled_pkg;

  localparam int NUM_LEDS = 64;
  localparam int LED_AW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam logic [7:0]        NUM_LEDS_W = 8'(NUM_LEDS);
  localparam logic [LED_AW-1:0] LAST_LED   = LED_AW'(NUM_LEDS - 1);
  localparam logic [4:0]        LED_BITS   = 5'd24;

  // command codes
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PERIOD   = 2'd0;
  localparam logic [1:0] REG_ZERO_HI  = 2'd1;
  localparam logic [1:0] REG_ONE_HI   = 2'd2;
  localparam logic [1:0] REG_TRAILER  = 2'd3;

  localparam logic [9:0] PERIOD_RST  = 10'd312;
  localparam logic [9:0] ZERO_HI_RST = 10'd100;
  localparam logic [9:0] ONE_HI_RST  = 10'd212;
  localparam logic [7:0] TRAILER_RST = 8'd60;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] led_num;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

  // classified command, front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic              idx_ok;
    logic [LED_AW-1:0] addr;
    logic [23:0]       grb;
  } cmd_t;

  typedef struct packed {
    logic [9:0] period_ticks;
    logic [9:0] zero_high_ticks;
    logic [9:0] one_high_ticks;
    logic [7:0] reset_periods;
  } cfg_t;

endpackage

[sv/aled_front.sv]
`timescale 1ns / 1ps
module aled_front import aled_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  input  logic  take,
  output logic  cmd_valid,
  output cmd_t  cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       put;

  always_comb begin
    decoded.kind   = item.cmd;
    decoded.idx_ok = {1'b0, item.led_num} < NUM_LEDS_W;
    decoded.addr   = item.led_num[LED_AW-1:0];
    decoded.grb    = {item.green, item.red, item.blue};
  end

  assign full      = (count == 2'd2);
  assign put       = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (put) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, put} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (put) slots[wr_ptr] <= decoded;
  end

endmodule

[sv/aled_resq.sv]
`timescale 1ns / 1ps
module aled_resq import aled_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    put,
  input  result_t res_in,
  output logic    room,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       get;

  assign room   = (count != 2'd2);
  assign empty  = (count == 2'd0);
  assign get    = pop && !empty;
  assign result = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (put) wr_ptr <= ~wr_ptr;
      if (get) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, put} - {1'b0, get};
    end
  end

  always_ff @(posedge clk) begin
    if (put) slots[wr_ptr] <= res_in;
  end

endmodule

[sv/aled_engine.sv]
`timescale 1ns / 1ps
module aled_engine import aled_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  input  logic    res_room,
  output logic    take,
  output result_t res
);

  logic [23:0]         mem [NUM_LEDS];
  logic [23:0]         rdata;
  logic [NUM_LEDS-1:0] marks;

  logic              sending, sending_next;
  logic [LED_AW-1:0] led_pos, led_next;
  logic [4:0]        bit_pos, bit_next;
  logic [9:0]        tick_pos, tick_next;
  logic [7:0]        trailer, trailer_next;
  logic [23:0]       shift_word, sw, sw_next;
  logic              shift_mark;
  logic              pending, pending_next;
  logic              load;
  logic              period_end;
  logic              trailer_end;
  logic [9:0]        high;

  assign take = cmd_valid && res_room;

  // freshly loaded word comes straight from the read register
  assign sw          = pending ? rdata : shift_word;
  assign period_end  = ({1'b0, tick_pos} + 11'd1) >= {1'b0, cfg.period_ticks};
  assign trailer_end = ({1'b0, trailer} + 9'd1) >= {1'b0, cfg.reset_periods};
  assign high        = sw[23] ? cfg.one_high_ticks : cfg.zero_high_ticks;

  always_comb begin
    sending_next = sending;
    led_next     = led_pos;
    bit_next     = bit_pos;
    tick_next    = tick_pos;
    trailer_next = trailer;
    sw_next      = sw;
    load         = 1'b0;
    res          = '0;
    res.busy_res = sending;
    if (take) begin
      case (cmd.kind)
        CMD_SET: begin
          res.rejected = !cmd.idx_ok;
        end
        CMD_START: begin
          res.busy_res = 1'b1;
          if (sending) begin
            res.rejected = 1'b1;
          end else begin
            sending_next = 1'b1;
            led_next     = '0;
            bit_next     = 5'd0;
            tick_next    = 10'd0;
            trailer_next = 8'd0;
            load         = 1'b1;
          end
        end
        CMD_TICK: begin
          if (sending) begin
            res.busy_res = 1'b1;
            if (bit_pos < LED_BITS) begin
              res.pin_level = shift_mark && (tick_pos < high);
              if (period_end) begin
                sw_next = {sw[22:0], 1'b0};
                if (bit_pos == LED_BITS - 5'd1) begin
                  if (led_pos != LAST_LED) begin
                    led_next = LED_AW'(led_pos + 1'b1);
                    bit_next = 5'd0;
                    load     = 1'b1;
                  end else begin
                    bit_next     = LED_BITS;
                    trailer_next = 8'd0;
                    if (cfg.reset_periods == 8'd0) begin
                      res.frame_done = 1'b1;
                      sending_next   = 1'b0;
                    end
                  end
                end else begin
                  bit_next = bit_pos + 5'd1;
                end
              end
            end else if (period_end) begin
              if (trailer_end) begin
                res.frame_done = 1'b1;
                sending_next   = 1'b0;
              end else begin
                trailer_next = trailer + 8'd1;
              end
            end
            tick_next = period_end ? 10'd0 : tick_pos + 10'd1;
          end
        end
        default: begin
        end
      endcase
    end
    pending_next = take ? load : pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending <= 1'b0;
      led_pos <= '0;
      bit_pos <= 5'd0;
      tick_pos <= 10'd0;
      trailer <= 8'd0;
      pending <= 1'b0;
      shift_mark <= 1'b0;
      shift_word <= '0;
      marks   <= '0;
    end else begin
      sending  <= sending_next;
      led_pos  <= led_next;
      bit_pos  <= bit_next;
      tick_pos <= tick_next;
      trailer  <= trailer_next;
      pending  <= pending_next;
      if (take) shift_word <= sw_next;
      if (load) shift_mark <= marks[led_next];
      if (take && cmd.kind == CMD_SET && cmd.idx_ok) marks[cmd.addr] <= 1'b1;
    end
  end

  // colour store: one write port, one registered read at the next LED
  always_ff @(posedge clk) begin
    if (take && cmd.kind == CMD_SET && cmd.idx_ok) mem[cmd.addr] <= cmd.grb;
    rdata <= mem[led_next];
  end

endmodule

[sv/addressable_led_grb_serializer.sv]
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// -------   -----------------------   ----------------------------------------
// command   push / full               item   (cmd, led_num, red, green, blue)
// result    empty / pop               result (pin_level, busy_res, frame_done,
//                                             rejected)
// config    cfg_valid / cfg_ready     cfg_index (2b), cfg_data (10b)
//
// One item per clock sustained while neither queue is full; an accepted item is
// registered in the front queue, and its result in the result queue, which
// drives the result ports. The engine retires one command per cycle while the
// result queue has room; the colour store read for the next LED is issued on
// the advancing tick and its registered data is used by the following item.
// Reset clears control state and written marks; no clearing pass.
// full rises when two commands wait in the front queue; the engine holds while
// two results wait to be popped.
module addressable_led_grb_serializer import aled_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  item_t      item,
  output logic       empty,
  input  logic       pop,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t    cfg;
  logic    cmd_valid;
  cmd_t    cmd;
  logic    take;
  logic    res_room;
  result_t res;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks    <= PERIOD_RST;
      cfg.zero_high_ticks <= ZERO_HI_RST;
      cfg.one_high_ticks  <= ONE_HI_RST;
      cfg.reset_periods   <= TRAILER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIOD:  cfg.period_ticks    <= cfg_data;
        REG_ZERO_HI: cfg.zero_high_ticks <= cfg_data;
        REG_ONE_HI:  cfg.one_high_ticks  <= cfg_data;
        REG_TRAILER: cfg.reset_periods   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: take and decode commands into a two-deep queue
  aled_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .take      (take),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // back: colour store, bit timing and frame sequencing
  aled_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .res_room  (res_room),
    .take      (take),
    .res       (res)
  );

  // result queue decouples the engine from the consumer
  aled_resq u_resq (
    .clk    (clk),
    .rst    (rst),
    .put    (take),
    .res_in (res),
    .room   (res_room),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
